FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each check is clocked on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define PVC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pvc: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define PVC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pvc: next-cycle check failed");

`endif

FILE: hw/rtl/pvc_pkg.sv
package pvc_pkg;

    // Angle constants in Q3.13 and Q.16.
    localparam logic signed [18:0] PI_Q13     = 19'sd25736;
    localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;
    localparam logic signed [20:0] PI_Q16     = 21'sd205887;

    // Root unit sizes: 34-bit sum of squares, 17-bit root.
    localparam int RAD_BITS  = 34;
    localparam int ROOT_BITS = 17;

    // Largest |e|^0.6 value in Q.11, and its width.
    localparam int POW_MAX = 4705;
    localparam int POW_W   = 13;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_LINEAR_GAIN  = 3'd0,
        CFG_ANGULAR_GAIN = 3'd1,
        CFG_DIST_DZ      = 3'd2,
        CFG_ANGLE_DZ     = 3'd3,
        CFG_MAX_LINEAR   = 3'd4,
        CFG_MAX_ANGULAR  = 3'd5,
        CFG_SLOW_THRESH  = 3'd6
    } t_cfg_index;

    // Operation codes of an input item.
    localparam logic OP_LEADER   = 1'b0;
    localparam logic OP_FOLLOWER = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] pose_x;
        logic signed [15:0] pose_y;
        logic signed [15:0] pose_heading;
    } t_in_item;

    typedef struct packed {
        logic        [14:0] linear_speed;
        logic signed [15:0] angular_speed;
    } t_out_item;

    // Arctangent of 2^-i in Q.16, rounded to nearest.
    function automatic logic [16:0] pvc_atan(input logic [4:0] idx);
        logic [16:0] v;
        unique case (idx)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // Brings an angle within one turn of (-pi, pi] into that range.
    function automatic logic signed [15:0] pvc_wrap(input logic signed [18:0] v);
        logic signed [18:0] r;
        if (v > PI_Q13) begin
            r = v - TWO_PI_Q13;
        end else if (v <= -PI_Q13) begin
            r = v + TWO_PI_Q13;
        end else begin
            r = v;
        end
        return r[15:0];
    endfunction

endpackage

FILE: hw/rtl/pursuit_velocity_controller.sv
// Pursuit velocity controller. A follower pose (opcode 1) is stored at its
// transfer and gives no result. A leader pose (opcode 0) gives one command,
// registered once the bit-serial square root and the CORDIC are both done
// and the later steps have run. The square root (started in S_SQY, after
// S_SQX) and the CORDIC (one cycle per iteration, started in the cycle
// after the transfer) run side by side. The later steps cover the heading
// error, the linear clamp and the |e|^0.6 table, which is read knot by knot
// in S_LIN and S_POW1. Inside the distance deadzone the sequencer goes from
// S_RUN straight to S_DONE. One item is in work at a time, so the next
// leader pose can transfer in the cycle after the command is registered.
// o_in_stall is high while an item is in work, and while a finished command
// waits for a free output register.
`include "assert_macros.svh"

module pursuit_velocity_controller
    import pvc_pkg::*;
#(
    parameter int POWER_TABLE_BITS  = 8,
    parameter int CORDIC_ITERATIONS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SH    = 15 - POWER_TABLE_BITS;
    localparam int KNOTS = (1 << POWER_TABLE_BITS) + 1;
    localparam int AW    = POWER_TABLE_BITS + 1;

    typedef logic [KNOTS-1:0][POW_W-1:0] t_pow_tab;

    // Knot k holds floor(fifth root of x^3 * 2^16), x = k << SH.
    function automatic t_pow_tab build_pow_tab();
        t_pow_tab          tab;
        longint unsigned   x;
        longint unsigned   n;
        longint unsigned   lo;
        longint unsigned   hi;
        longint unsigned   m;
        for (int k = 0; k < KNOTS; k++) begin
            x  = longint'(k) << SH;
            n  = x * x * x * 64'd65536;
            lo = 0;
            hi = POW_MAX;
            while (lo < hi) begin
                m = (lo + hi + 1) >> 1;
                if (m * m * m * m * m <= n) begin
                    lo = m;
                end else begin
                    hi = m - 1;
                end
            end
            tab[k] = POW_W'(lo);
        end
        return tab;
    endfunction

    localparam t_pow_tab POW_TAB = build_pow_tab();

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SQX    = 11'b00000000010,
        S_SQY    = 11'b00000000100,
        S_RUN    = 11'b00000001000,
        S_ERR    = 11'b00000010000,
        S_ABS    = 11'b00000100000,
        S_LIN    = 11'b00001000000,
        S_POW1   = 11'b00010000000,
        S_INTERP = 11'b00100000000,
        S_ANG    = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [15:0] r_lin_gain, r_ang_gain;
    logic [14:0] r_dist_dz, r_angle_dz, r_max_lin, r_max_ang, r_slow_thr;

    // Follower pose; the heading is kept already wrapped.
    logic signed [15:0] r_fx, r_fy, r_fhw;

    // Working registers.
    logic signed [16:0]   r_dx, r_dy;
    logic [RAD_BITS-1:0]  r_rad;
    logic [32:0]          r_lin_prod;
    logic signed [15:0]   r_err;
    logic [14:0]          r_aerr;
    logic [14:0]          r_lin;
    logic [POW_W-1:0]     r_rom_q;
    logic [POW_W-1:0]     r_p0;
    logic [POW_W-1:0]     r_pow;
    logic [28:0]          r_mag_prod;
    logic                 r_zero_cmd;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                   in_take;
    logic                   sqrt_done, cordic_done;
    logic [ROOT_BITS-1:0]   root;
    logic signed [15:0]     bearing;
    logic [RAD_BITS-1:0]    rad_sum;
    logic signed [33:0]     sq_y;
    logic [AW-1:0]          rom_addr;
    logic [POW_W-1:0]       diff;
    logic [POW_W+SH-1:0]    diff_prod;
    logic [23:0]            lin_rnd;
    logic [18:0]            mag_rnd;
    logic [14:0]            mag;
    logic                   out_free;

    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Sum of squares: dx^2 is held, dy^2 is added as the root unit starts.
    assign sq_y    = r_dy * r_dy;
    assign rad_sum = r_rad + RAD_BITS'(sq_y);

    pvc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_SQY),
        .i_rad   (rad_sum),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    pvc_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_SQX),
        .i_dx      (r_dx),
        .i_dy      (r_dy),
        .o_done    (cordic_done),
        .o_bearing (bearing)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_gain <= 16'd3686;
            r_ang_gain <= 16'd24576;
            r_dist_dz  <= 15'd51;
            r_angle_dz <= 15'd164;
            r_max_lin  <= 15'd8192;
            r_max_ang  <= 15'd20480;
            r_slow_thr <= 15'd6434;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINEAR_GAIN:  r_lin_gain <= i_cfg_data;
                CFG_ANGULAR_GAIN: r_ang_gain <= i_cfg_data;
                CFG_DIST_DZ:      r_dist_dz  <= i_cfg_data[14:0];
                CFG_ANGLE_DZ:     r_angle_dz <= i_cfg_data[14:0];
                CFG_MAX_LINEAR:   r_max_lin  <= i_cfg_data[14:0];
                CFG_MAX_ANGULAR:  r_max_ang  <= i_cfg_data[14:0];
                CFG_SLOW_THRESH:  r_slow_thr <= i_cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    // Follower pose store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx  <= '0;
            r_fy  <= '0;
            r_fhw <= '0;
        end else if (in_take && i_in.opcode == OP_FOLLOWER) begin
            r_fx  <= i_in.pose_x;
            r_fy  <= i_in.pose_y;
            r_fhw <= pvc_wrap(19'(i_in.pose_heading));
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_take && i_in.opcode == OP_LEADER) begin
                          n_state = S_SQX;
                      end
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_RUN;
            S_RUN:    if (sqrt_done && cordic_done) begin
                          n_state = (root < 17'(r_dist_dz)) ? S_DONE : S_ERR;
                      end
            S_ERR:    n_state = S_ABS;
            S_ABS:    n_state = S_LIN;
            S_LIN:    n_state = S_POW1;
            S_POW1:   n_state = S_INTERP;
            S_INTERP: n_state = S_ANG;
            S_ANG:    n_state = S_DONE;
            S_DONE:   if (out_free) begin
                          n_state = S_IDLE;
                      end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Power table read: knot idx, then knot idx + 1.
    assign rom_addr = AW'(r_aerr >> SH) + ((r_state == S_POW1) ? AW'(1) : AW'(0));

    always_ff @(posedge i_clk) begin
        r_rom_q <= POW_TAB[rom_addr];
    end

    // Arithmetic helpers for the later steps.
    always_comb begin
        diff      = r_rom_q - r_p0;
        diff_prod = diff * r_aerr[SH-1:0];
        lin_rnd   = 24'((r_lin_prod + 33'd512) >> 10);
        mag_rnd   = 19'((r_mag_prod + 29'd1024) >> 11);
        mag       = (mag_rnd > 19'(r_max_ang)) ? r_max_ang : mag_rnd[14:0];
    end

    // Datapath steps.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_dx       <= 17'(i_in.pose_x) - 17'(r_fx);
                r_dy       <= 17'(i_in.pose_y) - 17'(r_fy);
                r_zero_cmd <= 1'b0;
            end
            S_SQX: begin
                r_rad <= RAD_BITS'(r_dx * r_dx);
            end
            S_RUN: begin
                r_lin_prod <= r_lin_gain * root;
                r_zero_cmd <= (root < 17'(r_dist_dz));
            end
            S_ERR: begin
                r_err <= pvc_wrap(19'(bearing) - 19'(r_fhw));
            end
            S_ABS: begin
                r_aerr <= (r_err < 16'sd0) ? 15'(-r_err) : r_err[14:0];
                r_lin  <= (lin_rnd > 24'(r_max_lin)) ? r_max_lin : lin_rnd[14:0];
            end
            S_LIN: begin
                if (r_aerr > r_slow_thr) begin
                    r_lin <= r_lin >> 2;
                end
            end
            S_POW1: begin
                r_p0 <= r_rom_q;
            end
            S_INTERP: begin
                r_pow <= r_p0 + POW_W'(diff_prod >> SH);
            end
            S_ANG: begin
                r_mag_prod <= r_ang_gain * r_pow;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            if (r_zero_cmd) begin
                r_out.linear_speed  <= '0;
                r_out.angular_speed <= '0;
            end else begin
                r_out.linear_speed <= r_lin;
                if (r_aerr < r_angle_dz) begin
                    r_out.angular_speed <= '0;
                end else if (r_err < 16'sd0) begin
                    r_out.angular_speed <= -$signed({1'b0, mag});
                end else begin
                    r_out.angular_speed <= $signed({1'b0, mag});
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A command appears only from the final step.
    `PVC_ASSERT_IMP(a_out_from_done, $rose(r_out_valid), $past(r_state == S_DONE))
    // The angular command stays within its symmetric clamp.
    `PVC_ASSERT_IMP(a_ang_clamp, r_out_valid,
        (r_out.angular_speed <= $signed({1'b0, r_max_ang})) &&
        (r_out.angular_speed >= -$signed({1'b0, r_max_ang})))
    // A taken leader pose always leads to S_SQX, which starts the CORDIC.
    `PVC_ASSERT_NXT(a_leader_starts, in_take && i_in.opcode == OP_LEADER,
        r_state == S_SQX)

endmodule

FILE: hw/rtl/pvc_isqrt.sv
// Digit-serial integer square root: two radicand bits enter per cycle,
// one root bit leaves per cycle.
module pvc_isqrt
    import pvc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RAD_BITS-1:0]  i_rad,
    output logic                 o_done,
    output logic [ROOT_BITS-1:0] o_root
);

    logic [RAD_BITS-1:0]  r_rad;
    logic [ROOT_BITS+2:0] r_rem;
    logic [ROOT_BITS-1:0] r_root;
    logic [4:0]           r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [ROOT_BITS+2:0] rem_sh;
    logic [ROOT_BITS+2:0] trial;
    logic                 fits;

    // One restoring step on the next radicand digit.
    always_comb begin
        rem_sh = {r_rem[ROOT_BITS:0], r_rad[RAD_BITS-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    // Control: count the root bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'(ROOT_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: radicand shift register, partial remainder and root.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_BITS-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_BITS-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: hw/rtl/pvc_cordic.sv
// Iterative CORDIC in vectoring mode: one micro-rotation per cycle gives
// the bearing of (dx, dy) in Q3.13, wrapped to (-pi, pi].
module pvc_cordic
    import pvc_pkg::*;
#(
    parameter int ITERATIONS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_dx,
    input  logic signed [16:0] i_dy,
    output logic               o_done,
    output logic signed [15:0] o_bearing
);

    localparam int IW = $clog2(ITERATIONS);

    logic signed [27:0] r_x;
    logic signed [27:0] r_y;
    logic signed [20:0] r_z;
    logic [IW-1:0]      r_i;
    logic               r_busy;
    logic               r_done;
    logic               r_zero;

    logic signed [27:0] dx_ext;
    logic signed [27:0] dy_ext;
    logic signed [27:0] xs;
    logic signed [27:0] ys;
    logic signed [20:0] ang;
    logic signed [20:0] z_rnd;

    always_comb begin
        dx_ext = 28'(i_dx);
        dy_ext = 28'(i_dy);
        xs     = r_x >>> r_i;
        ys     = r_y >>> r_i;
        ang    = $signed({4'b0000, pvc_atan(5'(r_i))});
        z_rnd  = (r_z + 21'sd4) >>> 3;
    end

    // Control: iteration counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + IW'(1);
            if (r_i == IW'(ITERATIONS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: fold the vector into the right half-plane, then rotate
    // it towards the x axis while the angle accumulates.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_dx == 17'sd0) && (i_dy == 17'sd0);
            if (i_dx < 17'sd0) begin
                r_x <= (-dx_ext) <<< 8;
                r_y <= (-dy_ext) <<< 8;
                r_z <= (i_dy >= 17'sd0) ? PI_Q16 : -PI_Q16;
            end else begin
                r_x <= dx_ext <<< 8;
                r_y <= dy_ext <<< 8;
                r_z <= '0;
            end
        end else if (r_busy) begin
            if (r_y >= 28'sd0) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + ang;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - ang;
            end
        end
    end

    assign o_done    = r_done;
    assign o_bearing = r_zero ? 16'sd0 : pvc_wrap(z_rnd[18:0]);

endmodule

FILE: tb/tb_pursuit_velocity_controller.sv
module tb_pursuit_velocity_controller
    import pvc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int POWER_TABLE_BITS  = 8;
    localparam int CORDIC_ITERATIONS = 14;
    localparam int ITEMS_PER_PHASE   = 200;
    localparam int SETTLE_CYCLES     = 60;
    localparam int CYCLE_LIMIT       = 400000;
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd7;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [15:0] i_cfg_data;

    pursuit_velocity_controller #(
        .POWER_TABLE_BITS (POWER_TABLE_BITS),
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the controller's registers and follower pose.
    logic [15:0]        shadow_cfg [7];
    logic signed [15:0] shadow_fx;
    logic signed [15:0] shadow_fy;
    logic signed [15:0] shadow_fh;

    t_out_item pending_commands[$];
    bit        failed;
    bit        gaps_on;
    int        cycle_count;

    // Directed stimulus: a pose, and a command typed in where it is obvious.
    typedef struct {
        t_in_item  pose;
        bit        fixed;
        t_out_item command;
    } t_pose_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint root_floor(longint s);
        longint lo, hi, mid;
        lo = 0;
        hi = 131072;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            if (mid * mid <= s) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic int wrap_q13(int v);
        int r;
        r = v;
        while (r > 25736) r -= 51472;
        while (r <= -25736) r += 51472;
        return r;
    endfunction

    // CORDIC vectoring in Q.16, rounded back to Q3.13.
    function automatic int bearing_of(int dx, int dy);
        longint atan_tab [20] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
        longint x, y, z, xs, ys;
        if (dx == 0 && dy == 0) return 0;
        if (dx < 0) begin
            x = -longint'(dx) * 256;
            y = -longint'(dy) * 256;
            z = (dy >= 0) ? 205887 : -205887;
        end else begin
            x = longint'(dx) * 256;
            y = longint'(dy) * 256;
            z = 0;
        end
        for (int i = 0; i < CORDIC_ITERATIONS && i < 20; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z += atan_tab[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z -= atan_tab[i];
            end
        end
        return wrap_q13(int'((z + 4) >>> 3));
    endfunction

    // Floor fifth root of x^3 * 2^16 at one knot of the power table.
    function automatic longint power_knot(longint k);
        longint x, n, lo, hi, m;
        x = k << (15 - POWER_TABLE_BITS);
        n = x * x * x * 65536;
        lo = 0;
        hi = POW_MAX;
        while (lo < hi) begin
            m = (lo + hi + 1) / 2;
            if (m * m * m * m * m <= n) lo = m;
            else hi = m - 1;
        end
        return lo;
    endfunction

    function automatic longint power_06(int a);
        int     sh;
        longint idx, frac, p0, p1;
        sh   = 15 - POWER_TABLE_BITS;
        idx  = longint'(a & 32'h7FFF) >> sh;
        frac = longint'(a) & ((longint'(1) << sh) - 1);
        p0   = power_knot(idx);
        p1   = power_knot(idx + 1);
        return p0 + (((p1 - p0) * frac) >> sh);
    endfunction

    // Works out the command for a pose, or stores a follower pose.
    function automatic bit velocity_command(t_in_item pose, output t_out_item cmd);
        int     dx, dy, err, aerr;
        longint range_q10, lin, mag, ang;
        cmd = '0;
        if (pose.opcode == OP_FOLLOWER) begin
            shadow_fx = pose.pose_x;
            shadow_fy = pose.pose_y;
            shadow_fh = pose.pose_heading;
            return 1'b0;
        end
        dx        = int'(pose.pose_x) - int'(shadow_fx);
        dy        = int'(pose.pose_y) - int'(shadow_fy);
        range_q10 = root_floor(longint'(dx) * dx + longint'(dy) * dy);
        if (range_q10 < shadow_cfg[CFG_DIST_DZ]) return 1'b1;
        err  = wrap_q13(bearing_of(dx, dy) - wrap_q13(int'(shadow_fh)));
        aerr = (err < 0) ? -err : err;
        lin  = (longint'(shadow_cfg[CFG_LINEAR_GAIN]) * range_q10 + 512) >> 10;
        if (lin > shadow_cfg[CFG_MAX_LINEAR]) lin = shadow_cfg[CFG_MAX_LINEAR];
        if (aerr > shadow_cfg[CFG_SLOW_THRESH]) lin = lin >> 2;
        ang = 0;
        if (aerr >= shadow_cfg[CFG_ANGLE_DZ]) begin
            mag = (longint'(shadow_cfg[CFG_ANGULAR_GAIN]) * power_06(aerr) + 1024) >> 11;
            if (mag > shadow_cfg[CFG_MAX_ANGULAR]) mag = shadow_cfg[CFG_MAX_ANGULAR];
            ang = (err >= 0) ? mag : -mag;
        end
        cmd.linear_speed  = lin[14:0];
        cmd.angular_speed = ang[15:0];
        return 1'b1;
    endfunction

    // Sends one pose, called at a falling edge and returning at one.
    task automatic send_pose(t_in_item pose, bit fixed = 1'b0, t_out_item fixed_cmd = '0);
        int        gap;
        t_out_item cmd;
        gap = 0;
        while (gaps_on && gap < 20 && $urandom_range(99) < 32) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= pose;
        do @(posedge i_clk); while (o_in_stall);
        if (velocity_command(pose, cmd)) pending_commands.push_back(fixed ? fixed_cmd : cmd);
        @(negedge i_clk);
    endtask

    // One register write; the caller lowers valid after the last one.
    task automatic write_register(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < 3'd7) shadow_cfg[idx] = (idx < 3'd2) ? data : (data & 16'h7FFF);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        wait (pending_commands.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly leader poses, a quarter of them near the follower.
    task automatic random_poses(int count);
        t_in_item pose;
        for (int n = 0; n < count; n++) begin
            pose.opcode       = ($urandom_range(99) < 30) ? OP_FOLLOWER : OP_LEADER;
            pose.pose_x       = $urandom;
            pose.pose_y       = $urandom;
            pose.pose_heading = $urandom;
            if (pose.opcode == OP_LEADER && $urandom_range(3) == 0) begin
                pose.pose_x = shadow_fx + 16'($urandom_range(200)) - 16'sd100;
                pose.pose_y = shadow_fy + 16'($urandom_range(200)) - 16'sd100;
            end
            send_pose(pose);
        end
    endtask

    // Compare each command taken by the receiver with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_commands.size() == 0) begin
                $error("command with none expected: %0d %0d",
                       o_out.linear_speed, o_out.angular_speed);
                failed = 1'b1;
            end else begin
                want = pending_commands.pop_front();
                if (o_out.linear_speed !== want.linear_speed) begin
                    $error("linear_speed expected %0d actual %0d",
                           want.linear_speed, o_out.linear_speed);
                    failed = 1'b1;
                end
                if (o_out.angular_speed !== want.angular_speed) begin
                    $error("angular_speed expected %0d actual %0d",
                           want.angular_speed, o_out.angular_speed);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 32);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("pursuit_velocity_controller test failed");
            $finish;
        end
    end

    initial begin
        t_pose_row rows [$];
        logic [15:0] setting [7];
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        cycle_count = 0;
        failed      = 1'b0;
        gaps_on     = 1'b1;
        shadow_cfg  = '{16'd3686, 16'd24576, 16'd51, 16'd164, 16'd8192, 16'd20480, 16'd6434};
        shadow_fx   = '0;
        shadow_fy   = '0;
        shadow_fh   = '0;

        // Leader on the follower, just inside and just outside the deadzone,
        // extremes of every field, and follower poses at the corners and at the origin.
        rows = '{
            '{'{OP_LEADER, 16'sd0, 16'sd0, 16'sd0}, 1'b1, '0},
            '{'{OP_LEADER, 16'sd50, 16'sd0, 16'sd0}, 1'b1, '0},
            '{'{OP_LEADER, 16'sd51, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd32767, 16'sd32767, -16'sd32768}, 1'b0, '0},
            '{'{OP_LEADER, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0, '0},
            '{'{OP_LEADER, -16'sd32768, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, -16'sd32768, -16'sd1, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd0, 16'sd32767, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd0, -16'sd32768, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd1000, 16'sd10, 16'sd0}, 1'b0, '0},
            '{'{OP_FOLLOWER, 16'sd32767, -16'sd32768, 16'sd32767}, 1'b0, '0},
            '{'{OP_LEADER, -16'sd32768, 16'sd32767, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd32767, -16'sd32768, 16'sd0}, 1'b1, '0},
            '{'{OP_FOLLOWER, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd32767, -16'sd32768, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, -16'sd32700, 16'sd32767, 16'sd0}, 1'b0, '0},
            '{'{OP_FOLLOWER, 16'sd0, 16'sd0, 16'sd25736}, 1'b0, '0},
            '{'{OP_LEADER, 16'sd2000, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{OP_LEADER, -16'sd2000, 16'sd0, 16'sd0}, 1'b0, '0},
            '{'{OP_FOLLOWER, 16'sd0, 16'sd0, 16'sd0}, 1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: directed poses, then random ones.
        foreach (rows[r]) send_pose(rows[r].pose, rows[r].fixed, rows[r].command);
        random_poses(ITEMS_PER_PHASE);
        drain();

        // Four further settings: top of each width, all zero, random, and back to reset.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: setting = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                               16'hFFFF, 16'hFFFF, 16'hFFFF};
                1: setting = '{default: 16'h0000};
                2: setting = '{16'($urandom), 16'($urandom), 16'($urandom_range(400)),
                               16'($urandom_range(25736)), 16'($urandom_range(32767)),
                               16'($urandom_range(32767)), 16'($urandom_range(25736))};
                default: setting = '{16'd3686, 16'd24576, 16'd51, 16'd164,
                                     16'd8192, 16'd20480, 16'd6434};
            endcase
            write_register(CFG_UNUSED_INDEX, 16'($urandom));
            write_register(CFG_LINEAR_GAIN, setting[CFG_LINEAR_GAIN]);
            write_register(CFG_ANGULAR_GAIN, setting[CFG_ANGULAR_GAIN]);
            write_register(CFG_DIST_DZ, setting[CFG_DIST_DZ]);
            write_register(CFG_ANGLE_DZ, setting[CFG_ANGLE_DZ]);
            write_register(CFG_MAX_LINEAR, setting[CFG_MAX_LINEAR]);
            write_register(CFG_MAX_ANGULAR, setting[CFG_MAX_ANGULAR]);
            write_register(CFG_SLOW_THRESH, setting[CFG_SLOW_THRESH]);
            i_cfg_valid <= 1'b0;
            // The last phase runs back to back with no gaps on either side.
            gaps_on = (phase != 3);
            random_poses(ITEMS_PER_PHASE);
            drain();
        end

        if (!failed) begin
            $display("pursuit_velocity_controller test passed");
        end else begin
            $display("pursuit_velocity_controller test failed");
        end
        $finish;
    end

endmodule
